/* hw/rtl/tlc_pkg.sv */
// Shared constants for the two-level lru cache tag model.
// Holds register indexes, field widths, recency rank, access kinds and status codes.
// No dependencies.
package tlc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_L1_WAYS       = 3'd0;
    localparam logic [2:0] REG_L1_BLOCK_LOG2 = 3'd1;
    localparam logic [2:0] REG_L1_ROWS       = 3'd2;
    localparam logic [2:0] REG_L2_ENABLE     = 3'd3;
    localparam logic [2:0] REG_L2_WAYS       = 3'd4;
    localparam logic [2:0] REG_L2_BLOCK_LOG2 = 3'd5;
    localparam logic [2:0] REG_L2_ROWS       = 3'd6;

    // register field widths
    localparam int CFG_WAYS_W  = 5;
    localparam int CFG_BLOG2_W = 3;
    localparam int CFG_ROWS_W  = 9;
    localparam int CFG_DATA_W  = 9;

    // recency rank
    localparam int AGE_W = 4;
    localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;

    // access kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // result fields
    localparam int STATUS_W = 2;
    localparam int SET_OUT_W = 8;
    localparam int OUT_RAW_W = 2 * STATUS_W + 2 * SET_OUT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
    localparam logic [STATUS_W-1:0] L1_MISS  = 2'd0;
    localparam logic [STATUS_W-1:0] L1_HIT   = 2'd1;
    localparam logic [STATUS_W-1:0] L1_STORE = 2'd2;
    localparam logic [STATUS_W-1:0] L2_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] L2_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] L2_HIT   = 2'd2;
    localparam logic [STATUS_W-1:0] L2_STORE = 2'd3;

endpackage

/* hw/rtl/two_level_lru_cache_tag_model.sv */
// Top level of the two-level lru cache tag model.
// Uses tlc_pkg; holds one row memory per level and the divider sequencer.
//
// Usage:
//   The slave stream takes one access per item: tuser is the access kind
//   (load or store), tdata the word address. The master stream returns one
//   item per access: l1 code and set, l2 code and set.
//   Configuration goes through cfg_we/cfg_addr/cfg_data while no access is
//   in flight; register i of the list has index i.
//   Each item first runs a restoring divider, one quotient bit a cycle, that
//   gives set and tag of both levels at once. Then l1, and l2 when it is
//   probed, reads its set row from a synchronous memory and writes the
//   updated row back in the next cycle, and the done state loads the output
//   register. The next item is taken only once the sequencer is back in
//   idle, so the divider and row steps work on one item at a time.
//   Reset clears the per-row valid flags, so every set reads as empty; no
//   clearing pass is needed. Config returns to its reset values.
//   When the receiver stalls, the finished item waits in the output
//   register and the next item may still be taken and processed; it waits
//   at its last step until the output register frees.
module two_level_lru_cache_tag_model
    import tlc_pkg::*;
#(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 16,
    parameter int ADDR_BITS = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // access items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [((ADDR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,   // word_address
    input  logic                  s_axis_tuser,   // op
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata    // l1 code, l1 set, l2 code, l2 set
);

    localparam int CNT_W  = ($clog2(MAX_SETS + 1) > CFG_ROWS_W) ?
                            $clog2(MAX_SETS + 1) : CFG_ROWS_W;
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int STEP_W = $clog2(ADDR_BITS);

    typedef struct packed {
        logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
        logic [MAX_WAYS-1:0][AGE_W-1:0]     age;
        logic [MAX_WAYS-1:0]                valid;
    } row_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_RD1, ST_UP1, ST_RD2, ST_UP2, ST_DONE
    } state_t;

    // configuration registers, index 0 is l1 and 1 is l2
    logic [CFG_WAYS_W-1:0]  ways_reg  [2];
    logic [CFG_BLOG2_W-1:0] blog2_reg [2];
    logic [CFG_ROWS_W-1:0]  rows_reg  [2];
    logic                   l2_en_reg;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                store_reg;
    logic [CNT_W-1:0]    rem_reg [2];
    logic [ADDR_BITS-1:0] dq_reg [2];
    logic [STATUS_W-1:0] l1_st_reg;
    logic [STATUS_W-1:0] l2_st_reg;
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_data_reg;

    logic [CFG_WAYS_W-1:0] ways_eff [2];
    logic [CNT_W-1:0]      rows_eff [2];
    logic [CNT_W:0]        rem_sh   [2];
    logic                  ge       [2];
    logic                  hit_w    [2];
    logic [SET_W-1:0]      set_idx  [2];
    logic                  out_free;
    logic [OUT_RAW_W-1:0]  out_raw;

    // clamped counts
    always_comb
    begin
        for (int g = 0; g < 2; g++)
        begin
            if (ways_reg[g] == '0)
                ways_eff[g] = CFG_WAYS_W'(1);
            else if (ways_reg[g] > CFG_WAYS_W'(MAX_WAYS))
                ways_eff[g] = CFG_WAYS_W'(MAX_WAYS);
            else
                ways_eff[g] = ways_reg[g];
            if (rows_reg[g] == '0)
                rows_eff[g] = CNT_W'(1);
            else if (CNT_W'(rows_reg[g]) > CNT_W'(MAX_SETS))
                rows_eff[g] = CNT_W'(MAX_SETS);
            else
                rows_eff[g] = CNT_W'(rows_reg[g]);
        end
    end

    // one restoring divide step per level
    always_comb
    begin
        for (int g = 0; g < 2; g++)
        begin
            rem_sh[g]  = {rem_reg[g], dq_reg[g][ADDR_BITS-1]};
            ge[g]      = rem_sh[g] >= {1'b0, rows_eff[g]};
            set_idx[g] = rem_reg[g][SET_W-1:0];
        end
    end

    // per-level row memory and row update
    for (genvar g = 0; g < 2; g++) begin : g_lvl
        row_t                 mem [MAX_SETS];
        logic [MAX_SETS-1:0]  row_vld_reg;
        row_t                 rd_q;
        row_t                 cur;
        row_t                 nxt;
        logic                 we;
        logic [ADDR_BITS-1:0] tag;
        logic [MAX_WAYS-1:0]  in_rng, hitv, invv, maxv, sel;
        logic [WAY_W-1:0]     way;
        logic [AGE_W:0]       old;
        logic                 hit;

        assign we  = (g == 0) ? (state_reg == ST_UP1) : (state_reg == ST_UP2);
        assign tag = dq_reg[g];

        // row read every cycle at the current set, write back on update
        always_ff @(posedge clk)
        begin
            if (we)
                mem[set_idx[g]] <= nxt;
            rd_q <= mem[set_idx[g]];
        end

        // row written flags, cleared by reset
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                row_vld_reg <= '0;
            else if (we)
                row_vld_reg[set_idx[g]] <= 1'b1;
        end

        // hit search, victim choice and recency update
        always_comb
        begin
            cur = row_vld_reg[set_idx[g]] ? rd_q : '0;
            for (int i = 0; i < MAX_WAYS; i++)
            begin
                in_rng[i] = CFG_WAYS_W'(i) < ways_eff[g];
                hitv[i]   = in_rng[i] && cur.valid[i] && (cur.tag[i] == tag);
                invv[i]   = in_rng[i] && !cur.valid[i];
                maxv[i]   = in_rng[i];
                for (int j = 0; j < MAX_WAYS; j++)
                begin
                    if (in_rng[j] && (j < i) && (cur.age[j] >= cur.age[i]))
                        maxv[i] = 1'b0;
                    if (in_rng[j] && (j > i) && (cur.age[j] > cur.age[i]))
                        maxv[i] = 1'b0;
                end
            end
            hit = |hitv;
            if (hit)
                sel = hitv;
            else if (|invv)
                sel = invv;
            else
                sel = maxv;
            way = '0;
            for (int i = MAX_WAYS - 1; i >= 0; i--)
            begin
                if (sel[i])
                    way = WAY_W'(i);
            end
            if (!hit && (|invv))
                old = (AGE_W + 1)'(16);
            else
                old = {1'b0, cur.age[way]};
            nxt = cur;
            for (int i = 0; i < MAX_WAYS; i++)
            begin
                if ((WAY_W'(i) != way) && in_rng[i] && cur.valid[i]
                    && ({1'b0, cur.age[i]} < old))
                    nxt.age[i] = (cur.age[i] == AGE_MAX) ? AGE_MAX
                                                          : cur.age[i] + 1'b1;
            end
            nxt.age[way]   = '0;
            nxt.tag[way]   = tag;
            nxt.valid[way] = 1'b1;
            // direct-mapped: way 0 always refills, the rest are dropped
            if (ways_eff[g] == CFG_WAYS_W'(1))
            begin
                hit          = cur.valid[0] && (cur.tag[0] == tag);
                nxt.valid    = '0;
                nxt.age      = '0;
                nxt.tag      = cur.tag;
                nxt.tag[0]   = tag;
                nxt.valid[0] = 1'b1;
            end
            hit_w[g] = hit;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg[0]  <= CFG_WAYS_W'(1);
            ways_reg[1]  <= CFG_WAYS_W'(1);
            blog2_reg[0] <= '0;
            blog2_reg[1] <= '0;
            rows_reg[0]  <= CFG_ROWS_W'(1);
            rows_reg[1]  <= CFG_ROWS_W'(1);
            l2_en_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_L1_WAYS:       ways_reg[0]  <= cfg_data[CFG_WAYS_W-1:0];
                REG_L1_BLOCK_LOG2: blog2_reg[0] <= cfg_data[CFG_BLOG2_W-1:0];
                REG_L1_ROWS:       rows_reg[0]  <= cfg_data[CFG_ROWS_W-1:0];
                REG_L2_ENABLE:     l2_en_reg    <= cfg_data[0];
                REG_L2_WAYS:       ways_reg[1]  <= cfg_data[CFG_WAYS_W-1:0];
                REG_L2_BLOCK_LOG2: blog2_reg[1] <= cfg_data[CFG_BLOG2_W-1:0];
                REG_L2_ROWS:       rows_reg[1]  <= cfg_data[CFG_ROWS_W-1:0];
                default:           ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_axis_tready;
    assign out_raw  = {((l2_st_reg == L2_NONE) ? SET_OUT_W'(0)
                                               : rem_reg[1][SET_OUT_W-1:0]),
                       l2_st_reg, rem_reg[0][SET_OUT_W-1:0], l1_st_reg};

    // sequencer, divider and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            store_reg   <= 1'b0;
            l1_st_reg   <= L1_MISS;
            l2_st_reg   <= L2_NONE;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            for (int g = 0; g < 2; g++)
            begin
                rem_reg[g] <= '0;
                dq_reg[g]  <= '0;
            end
        end
        else
        begin
            // output register
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= OUT_W'(out_raw);
            end
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        store_reg <= (s_axis_tuser == OP_STORE);
                        step_reg  <= STEP_W'(ADDR_BITS - 1);
                        for (int g = 0; g < 2; g++)
                        begin
                            rem_reg[g] <= '0;
                            dq_reg[g]  <= s_axis_tdata[ADDR_BITS-1:0] >> blog2_reg[g];
                        end
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    for (int g = 0; g < 2; g++)
                    begin
                        rem_reg[g] <= ge[g] ? CNT_W'(rem_sh[g] - {1'b0, rows_eff[g]})
                                            : rem_sh[g][CNT_W-1:0];
                        dq_reg[g]  <= {dq_reg[g][ADDR_BITS-2:0], ge[g]};
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                        state_reg <= ST_RD1;
                end
                ST_RD1:
                    state_reg <= ST_UP1;
                ST_UP1:
                begin
                    l1_st_reg <= store_reg ? L1_STORE : (hit_w[0] ? L1_HIT : L1_MISS);
                    l2_st_reg <= L2_NONE;
                    if (l2_en_reg && (store_reg || !hit_w[0]))
                        state_reg <= ST_RD2;
                    else
                        state_reg <= ST_DONE;
                end
                ST_RD2:
                    state_reg <= ST_UP2;
                ST_UP2:
                begin
                    l2_st_reg <= store_reg ? L2_STORE : (hit_w[1] ? L2_HIT : L2_MISS);
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // an unprobed l2 reports set zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[11:10] == L2_NONE) |-> m_axis_tdata[19:12] == '0)
        else $error("l2 set nonzero without l2 access");

    // a store reports store status at both levels or none at l2
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == L1_STORE) |->
        (m_axis_tdata[11:10] == L2_STORE) || (m_axis_tdata[11:10] == L2_NONE))
        else $error("store status mismatch between levels");

    // an accepted item starts the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == ST_DIV)
        else $error("accepted item did not start division");

    // the partial remainder stays below the row count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> (rem_reg[0] < rows_eff[0]) && (rem_reg[1] < rows_eff[1]))
        else $error("divider remainder out of range");

endmodule
